>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OWPV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OWPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/owpv_pkg.sv
// ----------------------------------------------------------------------------
// owpv_pkg
// Types, widths, step codes and register defaults of the omni wheel PI block.
// ----------------------------------------------------------------------------
`default_nettype none

package owpv_pkg;

  localparam int NUM_WHEELS = 3;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam int BodyW   = 26;  // wheel body velocity, Q.8
  localparam int MeasW   = 32;
  localparam int ErrW    = 40;  // saturated error, Q.8
  localparam int ProdW   = 50;  // lane multiplier product register
  localparam int SumW    = 64;  // recombined 40x24 product
  localparam int IntegW  = 34;  // integrator / output, Q17.16
  localparam int TorqueW = 17;

  // sin(60 deg) in Q0.16
  localparam logic [16:0] Sin60Q16 = 17'd56756;

  localparam logic signed [ErrW-1:0] ErrMax = {1'b0, {(ErrW-1){1'b1}}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_INTEG_LIMIT = 3'd2,
    REG_OUT_LIMIT   = 3'd3,
    REG_WHEEL_GAIN  = 3'd4
  } reg_idx_e;

  // Sequencer steps, one per cycle of an item; the last step holds while the output is stalled.
  typedef logic [3:0] step_t;
  localparam step_t STEP_VYS     = 4'd0;   // vy * sin60, base terms
  localparam step_t STEP_BODY    = 4'd1;   // per-wheel body velocity
  localparam step_t STEP_TGT_MUL = 4'd2;   // body * wheel_gain
  localparam step_t STEP_ERR     = 4'd3;   // target - meas, saturate
  localparam step_t STEP_I_LO    = 4'd4;   // err_lo * integ_gain
  localparam step_t STEP_I_HI    = 4'd5;   // err_hi * integ_gain
  localparam step_t STEP_I_SUM   = 4'd6;   // combine; err_lo * prop_gain
  localparam step_t STEP_INTEG   = 4'd7;   // integrator update; err_hi * prop_gain
  localparam step_t STEP_P_SUM   = 4'd8;   // combine proportional term
  localparam step_t STEP_OUT     = 4'd9;   // output sum and clamp
  localparam step_t STEP_TORQUE  = 4'd10;  // truncate toward zero, commit
  localparam step_t STEP_SEND    = 4'd11;  // merge into output register

  typedef logic signed [BodyW-1:0]   body_t;
  typedef logic signed [MeasW-1:0]   meas_t;
  typedef logic signed [TorqueW-1:0] torque_t;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [15:0] integ_limit;
    logic [15:0] out_limit;
    logic [23:0] wheel_gain;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prop_gain:   24'd125829,
    integ_gain:  24'd1678,
    integ_limit: 16'd700,
    out_limit:   16'd1000,
    wheel_gain:  24'd116403
  };

  typedef struct packed {
    logic  busy;
    step_t step;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/owpv_if.sv
// ----------------------------------------------------------------------------
// owpv_in_if / owpv_out_if
// Valid/ready channels for the control period input and the torque result.
// ----------------------------------------------------------------------------
`default_nettype none

interface owpv_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] body_vx;
  logic signed [23:0] body_vy;
  logic signed [23:0] body_turn;
  logic signed [31:0] meas_left;
  logic signed [31:0] meas_right;
  logic signed [31:0] meas_rear;
  logic               fresh_left;
  logic               fresh_right;
  logic               fresh_rear;

  modport source (
    output valid, body_vx, body_vy, body_turn, meas_left, meas_right, meas_rear,
           fresh_left, fresh_right, fresh_rear,
    input  ready
  );
  modport sink (
    input  valid, body_vx, body_vy, body_turn, meas_left, meas_right, meas_rear,
           fresh_left, fresh_right, fresh_rear,
    output ready
  );
endinterface

interface owpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] torque_left;
  logic signed [16:0] torque_right;
  logic signed [16:0] torque_rear;
  logic               sent_left;
  logic               sent_right;
  logic               sent_rear;

  modport source (
    output valid, torque_left, torque_right, torque_rear,
           sent_left, sent_right, sent_rear,
    input  ready
  );
  modport sink (
    input  valid, torque_left, torque_right, torque_rear,
           sent_left, sent_right, sent_rear,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/owpv_kin.sv
// ----------------------------------------------------------------------------
// owpv_kin
// Inverse kinematics: body x/y/turn velocity to per-wheel body velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module owpv_kin import owpv_pkg::*; (
  input  wire logic               clk_i,
  input  wire ctrl_t              ctrl_i,
  input  wire logic signed [23:0] vx_i,
  input  wire logic signed [23:0] vy_i,
  input  wire logic signed [23:0] turn_i,
  output      body_t              body_o [NUM_WHEELS]
);

  logic signed [41:0] vys_d;
  logic signed [41:0] vys_q;
  logic signed [41:0] base_q;
  logic signed [24:0] rear_q;
  logic signed [41:0] left_sum;
  logic signed [41:0] right_sum;
  body_t              body_q [NUM_WHEELS];

  assign vys_d     = vy_i * $signed({1'b0, Sin60Q16});
  assign left_sum  = base_q - vys_q;
  assign right_sum = base_q + vys_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.busy && ctrl_i.step == STEP_VYS) begin
      vys_q  <= vys_d;
      // turn * 65536 - vx * 32768
      base_q <= {{2{turn_i[23]}}, turn_i, 16'b0} - {{3{vx_i[23]}}, vx_i, 15'b0};
      rear_q <= {turn_i[23], turn_i} + {vx_i[23], vx_i};
    end
    if (ctrl_i.busy && ctrl_i.step == STEP_BODY) begin
      body_q[0] <= left_sum[41:16];
      body_q[1] <= right_sum[41:16];
      body_q[2] <= {rear_q[24], rear_q};
    end
  end

  assign body_o = body_q;

endmodule

`default_nettype wire

>>> rtl/owpv_lane.sv
// ----------------------------------------------------------------------------
// owpv_lane
// One wheel PI loop: target scaling, error saturation, clamped integrator.
// ----------------------------------------------------------------------------
`default_nettype none

module owpv_lane import owpv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire ctrl_t   ctrl_i,
  input  wire cfg_t    cfg_i,
  input  wire body_t   body_i,
  input  wire meas_t   meas_i,
  input  wire logic    fresh_i,
  output      torque_t torque_o
);

  logic signed [25:0]        mul_a;
  logic        [23:0]        mul_b;
  logic signed [50:0]        mul_full;
  logic signed [25:0]        err_lo;
  logic signed [25:0]        err_hi;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [ProdW-1:0]   acc_q;
  logic signed [SumW-1:0]    sum_d;
  logic signed [SumW-1:0]    sum_q;
  logic signed [47:0]        term;
  logic signed [42:0]        diff;
  logic signed [42:0]        err_max_x;
  logic signed [ErrW-1:0]    err_d;
  logic signed [ErrW-1:0]    err_q;
  logic signed [48:0]        isum;
  logic signed [48:0]        ilim;
  logic signed [48:0]        ilim_neg;
  logic signed [IntegW-1:0]  integ_d;
  logic signed [IntegW-1:0]  integ_q;
  logic signed [48:0]        osum;
  logic signed [48:0]        olim;
  logic signed [48:0]        olim_neg;
  logic signed [IntegW-1:0]  outv_d;
  logic signed [IntegW-1:0]  outv_q;
  logic signed [IntegW-1:0]  outv_rnd;
  torque_t                   torque_q;

  // 40-bit error split for the 26x24 multiplier
  assign err_lo = {6'b0, err_q[19:0]};
  assign err_hi = {{6{err_q[ErrW-1]}}, err_q[ErrW-1:20]};

  always_comb begin
    case (ctrl_i.step)
      STEP_I_LO:  begin mul_a = err_lo; mul_b = cfg_i.integ_gain; end
      STEP_I_HI:  begin mul_a = err_hi; mul_b = cfg_i.integ_gain; end
      STEP_I_SUM: begin mul_a = err_lo; mul_b = cfg_i.prop_gain;  end
      STEP_INTEG: begin mul_a = err_hi; mul_b = cfg_i.prop_gain;  end
      default:    begin mul_a = body_i; mul_b = cfg_i.wheel_gain; end
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // acc holds the previous prod: the lo partial, issued first, sits in acc
  // while the hi partial is in prod (hi partial fits 44 signed bits)
  assign sum_d = {{(SumW-ProdW){acc_q[ProdW-1]}}, acc_q}
               + {prod_q[SumW-21:0], 20'b0};
  assign term  = sum_q[SumW-1:16];

  // error = floor(body*wg/256) - meas*256, saturated symmetric
  assign diff = {prod_q[ProdW-1], prod_q[ProdW-1:8]}
              - {{3{meas_i[MeasW-1]}}, meas_i, 8'b0};

  assign err_max_x = {{3{ErrMax[ErrW-1]}}, ErrMax};

  always_comb begin
    if (diff > err_max_x) begin
      err_d = ErrMax;
    end else if (diff < -err_max_x) begin
      err_d = -ErrMax;
    end else begin
      err_d = diff[ErrW-1:0];
    end
  end

  assign ilim     = {17'b0, cfg_i.integ_limit, 16'b0};
  assign ilim_neg = -ilim;
  assign isum     = {{15{integ_q[IntegW-1]}}, integ_q} + {term[47], term};

  always_comb begin
    if (isum > ilim) begin
      integ_d = ilim[IntegW-1:0];
    end else if (isum < ilim_neg) begin
      integ_d = ilim_neg[IntegW-1:0];
    end else begin
      integ_d = isum[IntegW-1:0];
    end
  end

  assign olim     = {17'b0, cfg_i.out_limit, 16'b0};
  assign olim_neg = -olim;
  assign osum     = {term[47], term} + {{15{integ_q[IntegW-1]}}, integ_q};

  always_comb begin
    if (osum > olim) begin
      outv_d = olim[IntegW-1:0];
    end else if (osum < olim_neg) begin
      outv_d = olim_neg[IntegW-1:0];
    end else begin
      outv_d = osum[IntegW-1:0];
    end
  end

  // bias negatives so the arithmetic shift truncates toward zero
  assign outv_rnd = outv_q[IntegW-1] ? outv_q + IntegW'(16'hFFFF) : outv_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[ProdW-1:0];
    acc_q  <= prod_q;
    sum_q  <= sum_d;
    if (ctrl_i.step == STEP_ERR) begin
      err_q <= err_d;
    end
    if (ctrl_i.step == STEP_OUT) begin
      outv_q <= outv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q  <= '0;
      torque_q <= '0;
    end else begin
      if (ctrl_i.busy && fresh_i && ctrl_i.step == STEP_INTEG) begin
        integ_q <= integ_d;
      end
      if (ctrl_i.busy && fresh_i && ctrl_i.step == STEP_TORQUE) begin
        torque_q <= outv_rnd[32:16];
      end
    end
  end

  assign torque_o = torque_q;

endmodule

`default_nettype wire

>>> rtl/omni_wheel_pi_velocity_control.sv
// ----------------------------------------------------------------------------
// omni_wheel_pi_velocity_control
// Three-wheel omni base PI velocity controller with clamped integrators.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ------------------------------------
//  in_i      in   valid / ready        body vx/vy/turn, 3x meas, 3x fresh
//  out_o     out  valid / ready        3x torque, 3x sent
//  cfg       in   cfg_we_i (no stall)  cfg_idx_i, cfg_wdata_i
//
//  An item runs through the step sequencer from input transfer to result valid:
//  2 kinematics steps, then 9 steps of each lane's single 26x24 multiplier and
//  its adders, then the merge into the output register.
//  Items do not overlap; a new input is taken on the cycle the previous
//  result is loaded into the output register.
//  A stalled output holds the sequencer on its last step; reset clears the
//  integrators, kept torques, the output valid and loads register defaults.
//
`default_nettype none

module omni_wheel_pi_velocity_control import owpv_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  owpv_in_if.sink                  in_i,
  owpv_out_if.source               out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata_i;
        REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_wdata_i;
        REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_wdata_i[15:0];
        REG_OUT_LIMIT:   cfg_q.out_limit   <= cfg_wdata_i[15:0];
        REG_WHEEL_GAIN:  cfg_q.wheel_gain  <= cfg_wdata_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Step sequencer
  // ---------------------------------------------------------------------
  logic  busy_q;
  step_t step_q;
  logic  out_valid_q;
  logic  out_free;
  logic  send;
  logic  in_xfer;
  ctrl_t ctrl;

  assign out_free = !out_valid_q || out_o.ready;
  // result merges into the output register on the last step
  assign send     = busy_q && step_q == STEP_SEND && out_free;
  assign in_i.ready = !busy_q || send;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_VYS;
    end else if (in_xfer) begin
      busy_q <= 1'b1;
      step_q <= STEP_VYS;
    end else if (send) begin
      busy_q <= 1'b0;
    end else if (busy_q && step_q != STEP_SEND) begin
      step_q <= step_q + step_t'(1);
    end
  end

  assign ctrl.busy = busy_q;
  assign ctrl.step = step_q;

  // ---------------------------------------------------------------------
  // Input holding registers (stable for the whole item)
  // ---------------------------------------------------------------------
  logic signed [23:0] vx_q;
  logic signed [23:0] vy_q;
  logic signed [23:0] turn_q;
  meas_t              meas_q  [NUM_WHEELS];
  logic               fresh_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      vx_q       <= in_i.body_vx;
      vy_q       <= in_i.body_vy;
      turn_q     <= in_i.body_turn;
      meas_q[0]  <= in_i.meas_left;
      meas_q[1]  <= in_i.meas_right;
      meas_q[2]  <= in_i.meas_rear;
      fresh_q[0] <= in_i.fresh_left;
      fresh_q[1] <= in_i.fresh_right;
      fresh_q[2] <= in_i.fresh_rear;
    end
  end

  // ---------------------------------------------------------------------
  // Kinematics and PI lanes
  // ---------------------------------------------------------------------
  body_t   body   [NUM_WHEELS];
  torque_t torque [NUM_WHEELS];

  owpv_kin u_kin (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .vx_i   (vx_q),
    .vy_i   (vy_q),
    .turn_i (turn_q),
    .body_o (body)
  );

  for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_lane
    owpv_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .cfg_i    (cfg_q),
      .body_i   (body[k]),
      .meas_i   (meas_q[k]),
      .fresh_i  (fresh_q[k]),
      .torque_o (torque[k])
    );
  end

  // ---------------------------------------------------------------------
  // Merge: output register
  // ---------------------------------------------------------------------
  torque_t out_torque_q [NUM_WHEELS];
  logic    out_sent_q   [NUM_WHEELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (send) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (send) begin
      out_torque_q <= torque;
      out_sent_q   <= fresh_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.torque_left  = out_torque_q[0];
  assign out_o.torque_right = out_torque_q[1];
  assign out_o.torque_rear  = out_torque_q[2];
  assign out_o.sent_left    = out_sent_q[0];
  assign out_o.sent_right   = out_sent_q[1];
  assign out_o.sent_rear    = out_sent_q[2];

endmodule

`default_nettype wire

>>> rtl/owpv_checker.sv
// ----------------------------------------------------------------------------
// owpv_checker
// Port-level checks of the omni wheel PI block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module owpv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [16:0] torque_left_i,
  input wire logic [16:0] torque_right_i,
  input wire logic [16:0] torque_rear_i,
  input wire logic        sent_left_i,
  input wire logic        sent_right_i,
  input wire logic        sent_rear_i
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `OWPV_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_stall, out_valid_i, "result dropped while stalled")
  `OWPV_ASSERT_NEXT(a_out_data_held, clk_i, rst_ni, out_stall, $stable(torque_left_i) && $stable(torque_right_i) && $stable(torque_rear_i) && $stable(sent_left_i) && $stable(sent_right_i) && $stable(sent_rear_i), "result changed while stalled")
  `OWPV_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_xfer, !in_ready_i, "second item taken while busy")
  `OWPV_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_xfer, ##1 !$rose(out_valid_i), "result right after input")

endmodule

bind omni_wheel_pi_velocity_control owpv_checker u_owpv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .torque_left_i  (out_o.torque_left),
  .torque_right_i (out_o.torque_right),
  .torque_rear_i  (out_o.torque_rear),
  .sent_left_i    (out_o.sent_left),
  .sent_right_i   (out_o.sent_right),
  .sent_rear_i    (out_o.sent_rear)
);

`default_nettype wire

>>> verif/omni_wheel_pi_velocity_control_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// omni_wheel_pi_velocity_control_tb
// Self-checking bench for the omni wheel PI velocity controller. Control
// periods are queued and driven over the input channel. Each accepted period
// runs through a behavioral copy of the kinematics and of the three clamped
// PI loops. Torque results are checked field by field in order, under several
// register settings and under sender/receiver idling and backpressure.
// ----------------------------------------------------------------------------

module omni_wheel_pi_velocity_control_tb;
  import owpv_pkg::*;

  // Run length: well above the slowest correct run (~1200 periods plus
  // idling, one long receiver hold-off and register loads).
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 16;   // > one period of the step sequencer
  localparam int HoldCycles   = 300;  // long receiver hold-off
  localparam int MaxPrinted   = 40;

  localparam longint BodyMax = 8388607;
  localparam longint BodyMin = -8388608;
  localparam longint MeasMax = 2147483647;
  localparam longint MeasMin = -2147483648;
  localparam longint Sin60   = longint'(Sin60Q16);
  localparam longint ErrSat  = longint'(ErrMax);

  // Register indexes past the end of the map; writes there must be dropped.
  localparam int FirstUnusedIdx = int'(REG_WHEEL_GAIN) + 1;
  localparam int LastIdx        = (1 << CfgIdxW) - 1;

  localparam logic [2:0] AllFresh  = 3'b111;
  localparam logic [2:0] NoneFresh = 3'b000;

  // One control period as driven on the input channel.
  typedef struct packed {
    logic signed [23:0] body_vx, body_vy, body_turn;
    logic signed [31:0] meas_left, meas_right, meas_rear;
    logic               fresh_left, fresh_right, fresh_rear;
  } period_t;

  // One torque command set as seen on the output channel.
  typedef struct packed {
    torque_t torque_left, torque_right, torque_rear;
    logic    sent_left, sent_right, sent_rear;
  } torque_cmd_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  owpv_in_if  period_if ();
  owpv_out_if torque_if ();

  omni_wheel_pi_velocity_control u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (period_if),
    .out_o       (torque_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Controller state mirrored by the bench
  // --------------------------------------------------------------------------
  cfg_t    gains = CfgReset;
  longint  integ_q16   [NUM_WHEELS] = '{default: 0};  // Q17.16 integrators
  torque_t kept_torque [NUM_WHEELS] = '{default: '0}; // last command per wheel

  period_t     period_q[$];    // periods waiting to be driven
  torque_cmd_t expected_q[$];  // torque sets predicted, oldest first

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  logic   hold_on        = 1'b0;
  int     mismatch_cnt   = 0;
  longint cycle_cnt      = 0;

  function automatic longint clip(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Kinematics plus one PI update per fresh wheel; stale wheels repeat the
  // torque they kept. Floor divisions are arithmetic shifts of 64-bit values.
  function automatic torque_cmd_t run_pi_period(period_t p);
    longint      vx, vy, turn, base, target, err, integ, outv;
    longint      body [NUM_WHEELS];
    longint      meas [NUM_WHEELS];
    logic        fresh [NUM_WHEELS];
    torque_cmd_t r;
    vx   = longint'(p.body_vx);
    vy   = longint'(p.body_vy);
    turn = longint'(p.body_turn);
    base = turn * 65536 - vx * 32768;
    // wheels at 240, 120 and 0 degrees
    body[0] = (base - vy * Sin60) >>> 16;
    body[1] = (base + vy * Sin60) >>> 16;
    body[2] = turn + vx;
    meas[0] = longint'(p.meas_left);
    meas[1] = longint'(p.meas_right);
    meas[2] = longint'(p.meas_rear);
    fresh[0] = p.fresh_left;
    fresh[1] = p.fresh_right;
    fresh[2] = p.fresh_rear;
    for (int k = 0; k < NUM_WHEELS; k++) begin
      if (fresh[k]) begin
        target = (body[k] * longint'(gains.wheel_gain)) >>> 8;
        // large errors saturate to the 40-bit range before any gain
        err    = clip(target - meas[k] * 256, ErrSat);
        integ  = integ_q16[k] + ((err * longint'(gains.integ_gain)) >>> 16);
        integ  = clip(integ, longint'(gains.integ_limit) * 65536);
        integ_q16[k] = integ;
        outv   = ((err * longint'(gains.prop_gain)) >>> 16) + integ;
        outv   = clip(outv, longint'(gains.out_limit) * 65536);
        kept_torque[k] = torque_t'(outv / 65536);  // truncates toward zero
      end
    end
    r.torque_left  = kept_torque[0];
    r.torque_right = kept_torque[1];
    r.torque_rear  = kept_torque[2];
    r.sent_left    = p.fresh_left;
    r.sent_right   = p.fresh_right;
    r.sent_rear    = p.fresh_rear;
    return r;
  endfunction

  task automatic report(string msg);
    if (mismatch_cnt < MaxPrinted) $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want)
      report($sformatf("%s got %0d expected %0d", name, $signed(got), $signed(want)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Signed value of w bits: extremes, full width, or a random narrower
  // magnitude so that small errors (unsaturated loops) show up often.
  function automatic longint rand_val(int w);
    longint raw;
    int     keep;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) != 0) ? (longint'(1) <<< (w - 1)) - 1
                                            : -(longint'(1) <<< (w - 1));
      1, 2, 3: keep = w;
      default: keep = $urandom_range(1, w - 1);
    endcase
    return (raw <<< (64 - keep)) >>> (64 - keep);
  endfunction

  function automatic logic [23:0] rand_reg(int w);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {24{1'b1}} >> (24 - w);
      2: return 24'($urandom_range(0, 2000));
      default: return 24'($urandom) & ({24{1'b1}} >> (24 - w));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.prop_gain   = rand_reg(24);
    c.integ_gain  = rand_reg(24);
    c.integ_limit = 16'(rand_reg(16));
    c.out_limit   = 16'(rand_reg(16));
    c.wheel_gain  = rand_reg(24);
    return c;
  endfunction

  task automatic queue_period(longint vx, longint vy, longint turn, longint ml,
                              longint mr, longint mb, logic [2:0] fresh);
    period_t p;
    p.body_vx     = vx[23:0];
    p.body_vy     = vy[23:0];
    p.body_turn   = turn[23:0];
    p.meas_left   = ml[31:0];
    p.meas_right  = mr[31:0];
    p.meas_rear   = mb[31:0];
    p.fresh_left  = fresh[2];
    p.fresh_right = fresh[1];
    p.fresh_rear  = fresh[0];
    period_q.push_back(p);
  endtask

  task automatic queue_random(int n);
    @(negedge clk_i);
    for (int i = 0; i < n; i++) begin
      // mostly fresh wheels so the loops keep integrating
      queue_period(rand_val(24), rand_val(24), rand_val(24),
                   rand_val(32), rand_val(32), rand_val(32),
                   {$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) != 0});
    end
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_PROP_GAIN:   gains.prop_gain   = data;
      REG_INTEG_GAIN:  gains.integ_gain  = data;
      REG_INTEG_LIMIT: gains.integ_limit = data[15:0];
      REG_OUT_LIMIT:   gains.out_limit   = data[15:0];
      REG_WHEEL_GAIN:  gains.wheel_gain  = data;
      default: ;  // past the map: ignored
    endcase
  endtask

  // Loads all five registers, then pokes the unused indexes with noise.
  task automatic load_config(cfg_t c);
    set_reg(REG_PROP_GAIN,   c.prop_gain);
    set_reg(REG_INTEG_GAIN,  c.integ_gain);
    set_reg(REG_INTEG_LIMIT, 24'(c.integ_limit));
    set_reg(REG_OUT_LIMIT,   24'(c.out_limit));
    set_reg(REG_WHEEL_GAIN,  c.wheel_gain);
    for (int i = FirstUnusedIdx; i <= LastIdx; i++)
      set_reg(CfgIdxW'(i), 24'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Block is idle once nothing is queued, offered or outstanding, plus a
  // sequencer's worth of cycles.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (period_q.size() != 0 || period_if.valid || expected_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(cfg_t c, int sidle, int rstall, int n);
    wait_drained();
    load_config(c);
    @(negedge clk_i);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    queue_random(n);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Input driver: offers queued periods; a transfer feeds the predictor with
  // exactly what the block took.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : period_feed
    period_t nxt;
    if (!rst_ni) begin
      period_if.valid <= 1'b0;
    end else begin
      if (period_if.valid && period_if.ready) begin
        expected_q.push_back(run_pi_period('{period_if.body_vx, period_if.body_vy,
            period_if.body_turn, period_if.meas_left, period_if.meas_right,
            period_if.meas_rear, period_if.fresh_left, period_if.fresh_right,
            period_if.fresh_rear}));
      end
      // slot is free when nothing is offered or the offer just transferred
      if (!period_if.valid || period_if.ready) begin
        if (period_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = period_q.pop_front();
          period_if.valid       <= 1'b1;
          period_if.body_vx     <= nxt.body_vx;
          period_if.body_vy     <= nxt.body_vy;
          period_if.body_turn   <= nxt.body_turn;
          period_if.meas_left   <= nxt.meas_left;
          period_if.meas_right  <= nxt.meas_right;
          period_if.meas_rear   <= nxt.meas_rear;
          period_if.fresh_left  <= nxt.fresh_left;
          period_if.fresh_right <= nxt.fresh_right;
          period_if.fresh_rear  <= nxt.fresh_rear;
        end else begin
          period_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: random stalls, the long hold-off, in-order compare.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : torque_check
    torque_cmd_t want;
    if (!rst_ni) begin
      torque_if.ready <= 1'b0;
    end else begin
      torque_if.ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
      if (torque_if.valid && torque_if.ready) begin
        if (expected_q.size() == 0) begin
          report("torque transfer with no period outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("torque_left",  torque_if.torque_left,  want.torque_left);
          check_field("torque_right", torque_if.torque_right, want.torque_right);
          check_field("torque_rear",  torque_if.torque_rear,  want.torque_rear);
          check_field("sent_left",    17'(torque_if.sent_left),  17'(want.sent_left));
          check_field("sent_right",   17'(torque_if.sent_right), 17'(want.sent_right));
          check_field("sent_rear",    17'(torque_if.sent_rear),  17'(want.sent_rear));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_wdata_i           = '0;
    period_if.valid       = 1'b0;
    period_if.body_vx     = '0;
    period_if.body_vy     = '0;
    period_if.body_turn   = '0;
    period_if.meas_left   = '0;
    period_if.meas_right  = '0;
    period_if.meas_rear   = '0;
    period_if.fresh_left  = 1'b0;
    period_if.fresh_right = 1'b0;
    period_if.fresh_rear  = 1'b0;
    torque_if.ready       = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed periods at reset register values, no idling.
    @(negedge clk_i);
    queue_period(0, 0, 0, 0, 0, 0, AllFresh);
    queue_period(0, 0, 0, 0, 0, 0, NoneFresh);  // stale right out of reset
    queue_period(BodyMax, 0, 0, 0, 0, 0, AllFresh);
    queue_period(BodyMin, 0, 0, 0, 0, 0, AllFresh);
    queue_period(0, BodyMax, 0, 0, 0, 0, AllFresh);
    queue_period(0, BodyMin, 0, 0, 0, 0, AllFresh);
    queue_period(0, 0, BodyMax, 0, 0, 0, AllFresh);
    queue_period(0, 0, BodyMin, 0, 0, 0, AllFresh);
    // error saturation both ways, integrators pinned to their clamps
    queue_period(BodyMax, BodyMax, BodyMax, MeasMin, MeasMin, MeasMin, AllFresh);
    queue_period(BodyMin, BodyMin, BodyMin, MeasMax, MeasMax, MeasMax, AllFresh);
    // one wheel fresh at a time; the others must repeat their kept torque
    queue_period(BodyMax, BodyMin, BodyMax, MeasMax, MeasMin, MeasMax, 3'b100);
    queue_period(BodyMax, BodyMin, BodyMax, MeasMax, MeasMin, MeasMax, 3'b010);
    queue_period(BodyMax, BodyMin, BodyMax, MeasMax, MeasMin, MeasMax, 3'b001);
    queue_period(BodyMin, BodyMax, BodyMin, MeasMin, MeasMax, 0, NoneFresh);
    // small errors: integrators wind up and back down inside the clamps
    repeat (4) queue_period(256, -512, 128, -1, 2, -3, AllFresh);
    repeat (3) queue_period(0, 0, 0, 5, -5, 1, AllFresh);
    queue_period(-1, -1, -1, -1, -1, -1, AllFresh);
    queue_period(1, 1, 1, 1, 1, 1, AllFresh);

    // All registers at their maximum, no idling.
    run_phase('{prop_gain: '1, integ_gain: '1, integ_limit: '1, out_limit: '1,
                wheel_gain: '1}, 0, 0, 150);
    run_phase(rand_cfg(), 63, 0, 200);   // sender mostly idle
    run_phase(rand_cfg(), 0, 63, 200);   // receiver mostly stalled
    run_phase(rand_cfg(), 30, 30, 200);  // both sides idle

    // All registers zero, with a long receiver hold-off while the sender
    // keeps offering: the output register and pipeline fill, input stalls.
    wait_drained();
    load_config('0);
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on <= 1'b0;
      end
      queue_random(150);
    join

    run_phase(rand_cfg(), 0, 0, 150);
    run_phase(CfgReset, 30, 30, 100);

    wait_drained();
    if (expected_q.size() != 0) report("torque sets still outstanding at end");
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
